// ----- hw/rtl/jar_pkg.sv -----
// jar_pkg: shared types and codes for the jump array reachability block
// controller states, command and status bundles, result status codes
// no dependencies
package jar_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RANGE    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_START,
    ST_POP,
    ST_FETCH_I,
    ST_CHECK,
    ST_PUSH_UP,
    ST_PUSH_DN,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // input transaction accepted
    logic clear;       // clear one visited entry
    logic push_start;  // push the start index
    logic pop;         // pop top of stack
    logic fetch_i;     // latch popped index, read its jump length
    logic check;       // latch jump length, read visited at i + a
    logic mark_hit;    // a zero was found
    logic push_up;     // push i + a if new, read visited at i - a
    logic push_dn;     // push i - a if new
    logic finish;      // load the output register, empty the array
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic start_bad;   // start index of the incoming last item out of range
    logic clear_last;  // current clear entry is the last one
    logic sp_zero;     // stack empty
    logic a_zero;      // fetched jump length is zero
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

// ----- hw/rtl/jar_ctrl.sv -----
// jar_ctrl: sequencing state machine for load, clear and depth-first search
// depends on jar_pkg (state_t, cmd_t, sts_t)
module jar_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          is_last,
  output logic          in_ready,
  input  jar_pkg::sts_t sts,
  output jar_pkg::cmd_t cmd
);

  jar_pkg::state_t state;
  jar_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jar_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      jar_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (is_last) begin
            state_next = sts.start_bad ? jar_pkg::ST_DONE : jar_pkg::ST_CLEAR;
          end
        end
      end
      jar_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = jar_pkg::ST_START;
        end
      end
      jar_pkg::ST_START: begin
        cmd.push_start = 1'b1;
        state_next     = jar_pkg::ST_POP;
      end
      jar_pkg::ST_POP: begin
        if (sts.sp_zero) begin
          state_next = jar_pkg::ST_DONE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = jar_pkg::ST_FETCH_I;
        end
      end
      jar_pkg::ST_FETCH_I: begin
        cmd.fetch_i = 1'b1;
        state_next  = jar_pkg::ST_CHECK;
      end
      jar_pkg::ST_CHECK: begin
        if (sts.a_zero) begin
          cmd.mark_hit = 1'b1;
          state_next   = jar_pkg::ST_DONE;
        end else begin
          cmd.check  = 1'b1;
          state_next = jar_pkg::ST_PUSH_UP;
        end
      end
      jar_pkg::ST_PUSH_UP: begin
        cmd.push_up = 1'b1;
        state_next  = jar_pkg::ST_PUSH_DN;
      end
      jar_pkg::ST_PUSH_DN: begin
        cmd.push_dn = 1'b1;
        state_next  = jar_pkg::ST_POP;
      end
      jar_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = jar_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = jar_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// ----- hw/rtl/jar_dp.sv -----
// jar_dp: datapath with jump store, visited map, index stack and result register
// depends on jar_pkg (cmd_t, sts_t, status codes)
module jar_dp #(
  parameter int MAX_LEN = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  jar_pkg::cmd_t cmd,
  output jar_pkg::sts_t sts,
  input  logic [9:0]    element_value,
  input  logic          is_last,
  input  logic [9:0]    start_index,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          reachable,
  output logic [1:0]    status
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = ((AW > 10) ? AW : 10) + 1;

  // memories
  logic [9:0]    jump_mem  [MAX_LEN];
  logic [AW-1:0] stack_mem [MAX_LEN];
  logic          vis_mem   [MAX_LEN];

  logic [9:0]    jump_rdata;
  logic [AW-1:0] stack_rdata;
  logic          vis_rdata;

  // control registers
  logic [CW-1:0] cnt;
  logic          ovf;
  logic [CW-1:0] sp;
  logic          hit;

  // payload registers
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] start_reg;
  logic [AW-1:0] node_i;
  logic [9:0]    jump_a;
  logic [AW-1:0] up_idx;
  logic          up_ok;
  logic [AW-1:0] dn_idx;
  logic          dn_ok;
  logic [1:0]    res_status;

  // load side arithmetic
  logic          has_room;
  logic [CW-1:0] cnt_after;
  logic [SW-1:0] start_ext;
  logic          ovf_now;

  assign has_room  = cnt < CW'(MAX_LEN);
  assign cnt_after = has_room ? (cnt + CW'(1)) : cnt;
  assign start_ext = SW'(start_index);
  assign ovf_now   = ovf | ~has_room;

  // search side arithmetic
  logic [CW-1:0] sp_dec;
  logic [SW-1:0] up_sum;
  logic [SW-1:0] dn_diff;
  logic [AW-1:0] vis_raddr;
  logic [AW-1:0] push_idx;
  logic          push_en;
  logic          vis_we;
  logic [AW-1:0] vis_waddr;
  logic          vis_wdata;

  assign sp_dec  = sp - CW'(1);
  assign up_sum  = SW'(node_i) + SW'(jump_rdata);
  assign dn_diff = SW'(node_i) - SW'(jump_a);

  // visited read address: upper target during check, lower target after it
  assign vis_raddr = cmd.check ? up_sum[AW-1:0] : dn_diff[AW-1:0];

  // push selection
  always_comb begin
    push_en  = 1'b0;
    push_idx = start_reg;
    if (cmd.push_start) begin
      push_en  = 1'b1;
      push_idx = start_reg;
    end else if (cmd.push_up) begin
      push_en  = up_ok & ~vis_rdata;
      push_idx = up_idx;
    end else if (cmd.push_dn) begin
      push_en  = dn_ok & ~vis_rdata;
      push_idx = dn_idx;
    end
  end

  // visited write port: clear pass or mark on push
  assign vis_we    = cmd.clear | push_en;
  assign vis_waddr = cmd.clear ? clr_idx : push_idx;
  assign vis_wdata = ~cmd.clear;

  // jump store
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      jump_mem[cnt[AW-1:0]] <= element_value;
    end
    if (cmd.fetch_i) begin
      jump_rdata <= jump_mem[stack_rdata];
    end
  end

  // index stack
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[sp[AW-1:0]] <= push_idx;
    end
    if (cmd.pop) begin
      stack_rdata <= stack_mem[sp_dec[AW-1:0]];
    end
  end

  // visited map
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rdata <= vis_mem[vis_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      ovf       <= 1'b0;
      sp        <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (has_room) begin
          cnt <= cnt_after;
        end else begin
          ovf <= 1'b1;
        end
        if (is_last) begin
          hit <= 1'b0;
          sp  <= '0;
        end
      end
      if (cmd.mark_hit) begin
        hit <= 1'b1;
      end
      if (cmd.pop) begin
        sp <= sp_dec;
      end else if (push_en) begin
        sp <= sp + CW'(1);
      end
      if (cmd.finish) begin
        cnt       <= '0;
        ovf       <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load && is_last) begin
      start_reg <= start_ext[AW-1:0];
      clr_idx   <= '0;
      if (start_ext >= SW'(cnt_after)) begin
        res_status <= jar_pkg::STATUS_RANGE;
      end else if (ovf_now) begin
        res_status <= jar_pkg::STATUS_OVERFLOW;
      end else begin
        res_status <= jar_pkg::STATUS_OK;
      end
    end
    if (cmd.clear) begin
      clr_idx <= clr_idx + AW'(1);
    end
    if (cmd.fetch_i) begin
      node_i <= stack_rdata;
    end
    if (cmd.check) begin
      jump_a <= jump_rdata;
      up_idx <= up_sum[AW-1:0];
      up_ok  <= up_sum < SW'(cnt);
    end
    if (cmd.push_up) begin
      dn_idx <= dn_diff[AW-1:0];
      dn_ok  <= SW'(jump_a) <= SW'(node_i);
    end
    if (cmd.finish) begin
      reachable <= hit;
      status    <= res_status;
    end
  end

  // status to controller
  always_comb begin
    sts.start_bad  = start_ext >= SW'(cnt_after);
    sts.clear_last = (CW'(clr_idx) + CW'(1)) == cnt;
    sts.sp_zero    = sp == '0;
    sts.a_zero     = jump_rdata == '0;
    sts.out_free   = ~out_valid | out_ready;
  end

endmodule

// ----- hw/rtl/jump_array_reachability.sv -----
// jump_array_reachability: top level joining jar_ctrl and jar_dp, types from jar_pkg
// throughput: one element transaction per cycle; a last element blocks input until its result
// after a last element: clear of the held visited entries, start push, then per popped index
// pop, fetch, check, push up and push down (ending at check on a zero), a final pop if the
// stack runs dry, then a free output register; an out-of-range start goes straight to it
// reset clears control state only; jump store and stack are not cleared, visited per query
module jump_array_reachability #(
  parameter int MAX_LEN = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [9:0] element_value,
  input  logic       is_last,
  input  logic [9:0] start_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       reachable,
  output logic [1:0] status
);

  jar_pkg::cmd_t cmd;
  jar_pkg::sts_t sts;

  // sequencing
  jar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .is_last  (is_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and arithmetic
  jar_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .element_value (element_value),
    .is_last       (is_last),
    .start_index   (start_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reachable     (reachable),
    .status        (status)
  );

endmodule

// ----- bench/jump_array_reachability_tb.sv -----
// jump_array_reachability_tb: self-checking bench for the jump array reachability block
// loads arrays by element, predicts verdicts not typed by hand, checks every result
// depends on jar_pkg and jump_array_reachability
`timescale 1ns / 1ps

module jump_array_reachability_tb;

  localparam int CAPACITY        = 1024;
  localparam int RANDOM_ITEMS    = 1630;
  localparam int OVERFLOW_AFTER  = 500;
  localparam int WATCHDOG_LIMIT  = 40000;
  localparam int HOLD_OFF_AT     = 30;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int DRAIN_CYCLES    = 100;
  localparam int PLAN_ROWS       = 20;

  typedef struct packed {
    logic       reach;
    logic [1:0] status;
  } verdict_t;

  // verdict typed in by hand for a directed transaction
  typedef struct packed {
    logic     fixed;
    verdict_t v;
  } typed_t;

  typedef struct packed {
    logic [9:0] value;
    logic       last;
    logic [9:0] start;
    logic       fixed;
    logic       reach;
    logic [1:0] status;
  } stim_row_t;

  // how the jump lengths of a random array are drawn
  typedef enum int {
    FILL_SHORT_HOPS,
    FILL_NO_ZERO,
    FILL_WIDE,
    FILL_ONE_ZERO
  } fill_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [9:0] element_value = '0;
  logic       is_last = 1'b0;
  logic [9:0] start_index = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       reachable;
  logic [1:0] status;

  // predictor state
  logic [9:0] jump_mem [CAPACITY];
  bit         seen_map [CAPACITY];
  int         walk_stack [CAPACITY];
  int         held_count = 0;
  bit         overflow_flag = 1'b0;

  verdict_t   verdict_q [$];
  typed_t     typed_q [$];

  int  errors = 0;
  int  items_sent = 0;
  int  arrays_done = 0;
  int  results_seen = 0;
  int  reached_count = 0;
  int  range_count = 0;
  int  overflow_count = 0;
  int  idle_cycles = 0;
  bit  sender_burst = 1'b0;
  bit  receiver_burst = 1'b0;

  // directed arrays: single elements, extremes, range errors, up and down walks
  stim_row_t plan [PLAN_ROWS] = '{
    '{10'd0,    1'b1, 10'd0,    1'b1, 1'b1, jar_pkg::STATUS_OK},
    '{10'd5,    1'b1, 10'd0,    1'b1, 1'b0, jar_pkg::STATUS_OK},
    '{10'd0,    1'b1, 10'd1,    1'b1, 1'b0, jar_pkg::STATUS_RANGE},
    '{10'd1023, 1'b1, 10'd1023, 1'b1, 1'b0, jar_pkg::STATUS_RANGE},
    '{10'd1023, 1'b0, 10'd1023, 1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd0,    1'b1, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd0,    1'b0, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd1,    1'b0, 10'd512,  1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd1,    1'b1, 10'd2,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd1,    1'b0, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd1,    1'b1, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd2,    1'b0, 10'd341,  1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd4,    1'b0, 10'd682,  1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd1,    1'b0, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd2,    1'b0, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd0,    1'b1, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd1,    1'b0, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd1,    1'b0, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd1,    1'b0, 10'd0,    1'b0, 1'b0, jar_pkg::STATUS_OK},
    '{10'd2,    1'b1, 10'd3,    1'b0, 1'b0, jar_pkg::STATUS_OK}
  };

  jump_array_reachability #(
    .MAX_LEN(CAPACITY)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .element_value(element_value),
    .is_last      (is_last),
    .start_index  (start_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reachable    (reachable),
    .status       (status)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // depth-first walk over the held elements, each index pushed at most once
  function automatic bit zero_reachable(input int origin);
    int k;
    int depth;
    int pos;
    int hop;
    for (k = 0; k < CAPACITY; k++) seen_map[k] = 1'b0;
    seen_map[origin] = 1'b1;
    walk_stack[0] = origin;
    depth = 1;
    while (depth > 0) begin
      depth--;
      pos = walk_stack[depth];
      hop = int'(jump_mem[pos]);
      if (hop == 0) return 1'b1;
      if (pos + hop < held_count && !seen_map[pos + hop]) begin
        seen_map[pos + hop] = 1'b1;
        walk_stack[depth] = pos + hop;
        depth++;
      end
      if (hop <= pos && !seen_map[pos - hop]) begin
        seen_map[pos - hop] = 1'b1;
        walk_stack[depth] = pos - hop;
        depth++;
      end
    end
    return 1'b0;
  endfunction

  // offer one element transaction after a random gap and wait for acceptance
  task automatic send_item(input logic [9:0] value, input logic last,
                           input logic [9:0] start, input typed_t tag);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= value;
    is_last       <= last;
    start_index   <= start;
    typed_q.insert(typed_q.size(), tag);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // one whole array, closed by its last element carrying the start index
  task automatic send_array(input int len, input fill_mode_t mode, input logic [9:0] start);
    int         k;
    int         hi;
    int         zero_at;
    logic [9:0] value;
    typed_t     none;
    none = '0;
    hi = (len > 1023) ? 1023 : len;
    zero_at = $urandom_range(0, len - 1);
    sender_burst = ($urandom_range(0, 3) == 0);
    for (k = 0; k < len; k++) begin
      case (mode)
        FILL_SHORT_HOPS: value = 10'($urandom_range(0, hi));
        FILL_NO_ZERO:    value = 10'($urandom_range(1, hi));
        FILL_WIDE:       value = 10'($urandom);
        default:         value = (k == zero_at) ? 10'd0 : 10'($urandom_range(1, hi));
      endcase
      send_item(value, k == len - 1, (k == len - 1) ? start : 10'($urandom), none);
    end
  endtask

  // main sequence: reset, directed table, random arrays, drain, verdict
  initial begin : stimulus
    int         r;
    int         len;
    int         base;
    int         pick;
    bit         overflow_done;
    logic [9:0] start;
    typed_t     tag;
    overflow_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (r = 0; r < PLAN_ROWS; r++) begin
      tag.fixed    = plan[r].fixed;
      tag.v.reach  = plan[r].reach;
      tag.v.status = plan[r].status;
      send_item(plan[r].value, plan[r].last, plan[r].start, tag);
    end

    // random arrays, mostly short, one past capacity
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (!overflow_done && items_sent - base > OVERFLOW_AFTER) begin
        send_array(CAPACITY + $urandom_range(1, 6), FILL_ONE_ZERO, 10'd1023);
        overflow_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 14) len = $urandom_range(1, 12);
        else if (pick < 19) len = $urandom_range(13, 64);
        else len = $urandom_range(65, 200);
        if ($urandom_range(0, 9) == 0) start = 10'($urandom);
        else start = 10'($urandom_range(0, len - 1));
        send_array(len, fill_mode_t'($urandom_range(0, 3)), start);
      end
    end
    in_valid <= 1'b0;

    // let the scoreboard take the final transaction before waiting on results
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d arrays over %0d element transactions, %0d results checked",
             arrays_done, items_sent, results_seen);
    $display("  %0d reachable, %0d start out of range, %0d over capacity",
             reached_count, range_count, overflow_count);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side: random stalls, no-stall stretches, one long hold-off
  initial begin : receiver
    int stall;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      else if (receiver_burst) stall = 0;
      else stall = $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) receiver_burst = !receiver_burst;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // predict on accepted elements, compare accepted results in order
  always @(posedge clk) begin : scoreboard
    typed_t   tag;
    verdict_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual reachable %0d status %0d",
                   $time, reachable, status);
        end else begin
          want = verdict_q.pop_front();
          results_seen++;
          if (want.reach) reached_count++;
          if (want.status == jar_pkg::STATUS_RANGE) range_count++;
          if (want.status == jar_pkg::STATUS_OVERFLOW) overflow_count++;
          if (reachable !== want.reach) begin
            errors++;
            $display("%0t: reachable mismatch, expected %0d actual %0d",
                     $time, want.reach, reachable);
          end
          if (status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, status);
          end
        end
      end
      if (in_valid && in_ready) begin
        tag = typed_q.pop_front();
        if (held_count < CAPACITY) begin
          jump_mem[held_count] = element_value;
          held_count++;
        end else begin
          overflow_flag = 1'b1;
        end
        if (is_last) begin
          if (int'(start_index) >= held_count) begin
            want.reach  = 1'b0;
            want.status = jar_pkg::STATUS_RANGE;
          end else begin
            want.reach  = zero_reachable(int'(start_index));
            want.status = overflow_flag ? jar_pkg::STATUS_OVERFLOW : jar_pkg::STATUS_OK;
          end
          if (tag.fixed) want = tag.v;
          verdict_q.insert(verdict_q.size(), want);
          held_count    = 0;
          overflow_flag = 1'b0;
          arrays_done++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
